// ===== sv/cmn_pkg.sv =====
// Shared types, constants and calendar helper functions for the month navigator.
package cmn_pkg;

	localparam int GRID_CELLS = 42;

	localparam logic [13:0] YEAR_MIN = 14'd1;
	localparam logic [13:0] YEAR_MAX = 14'd9999;
	localparam logic [3:0] MONTH_MIN = 4'd1;
	localparam logic [3:0] MONTH_MAX = 4'd12;
	localparam logic [3:0] MONTH_MAR = 4'd3;
	localparam logic [3:0] MONTH_FEB = 4'd2;
	localparam logic [4:0] DAY_MIN = 5'd1;
	localparam logic [4:0] MIN_MONTH_LEN = 5'd28;
	localparam logic [4:0] LEAP_FEB_LEN = 5'd29;
	localparam logic [4:0] BAD_MONTH_LEN = 5'd30;
	localparam logic [3:0] WEEK_DAYS = 4'd7;
	localparam logic [6:0] CELL_OFS = 7'd2;

	localparam logic [8:0] CYCLE_YEARS = 9'd400;
	localparam logic [8:0] CENTURY = 9'd100;

	localparam logic [13:0] RESET_YEAR = 14'd2026;
	localparam logic [3:0] RESET_MONTH = 4'd3;
	localparam logic [4:0] RESET_DAY = 5'd6;
	localparam logic [8:0] RESET_YMOD = 9'(RESET_YEAR % CYCLE_YEARS);
	localparam logic [2:0] RESET_FD = 3'd1;

	// floor(y / 100) = (y * 5243) >> 19 for every 14-bit y
	localparam logic [26:0] RECIP_100 = 27'd5243;
	localparam int RECIP_100_SHIFT = 19;
	// floor(s / 7) = (s * 293) >> 11 for every Zeller sum (below 700)
	localparam logic [19:0] RECIP_7 = 20'd293;
	localparam int RECIP_7_SHIFT = 11;

	localparam logic [4:0] BASE_LEN [12] = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	typedef enum logic [1:0] {
		FUNC_PREV = 2'd0,
		FUNC_NEXT = 2'd1,
		FUNC_GOTO = 2'd2,
		FUNC_CELL = 2'd3
	} func_t;

	typedef struct packed {
		func_t func;
		logic [5:0] cell_req;
		logic [13:0] target_year;
		logic [3:0] target_month;
		logic [4:0] target_day;
	} cmd_t;

	typedef struct packed {
		logic [13:0] shown_year;
		logic [3:0] shown_month;
		logic [4:0] chosen_day;
		logic [4:0] month_length;
		logic [2:0] first_weekday;
		logic accepted;
	} rsp_t;

	typedef struct packed {
		func_t func;
		logic [5:0] cell_idx;
		logic [13:0] year;
		logic [3:0] month;
		logic [4:0] day;
		logic [8:0] ymod;
		logic [2:0] fd;
	} goto_t;

	function automatic logic leap_of(input logic [8:0] ymod);
		logic lp;
		lp = (ymod == 9'd0) ||
			((ymod[1:0] == 2'd0) && (ymod != CENTURY) && (ymod != 9'd200) &&
			(ymod != 9'd300));
		return lp;
	endfunction

	function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
		logic [4:0] d;
		d = BAD_MONTH_LEN;
		if (m >= MONTH_MIN && m <= MONTH_MAX) begin
			d = BASE_LEN[m - MONTH_MIN];
		end
		if (m == MONTH_FEB && leap) begin
			d = LEAP_FEB_LEN;
		end
		return d;
	endfunction

	// floor(13 * (m + 1) / 5) for Zeller months 3..14
	function automatic logic [5:0] zeller_m(input logic [3:0] m);
		logic [5:0] r;
		case (m)
			4'd3: r = 6'd10;
			4'd4: r = 6'd13;
			4'd5: r = 6'd15;
			4'd6: r = 6'd18;
			4'd7: r = 6'd20;
			4'd8: r = 6'd23;
			4'd9: r = 6'd26;
			4'd10: r = 6'd28;
			4'd11: r = 6'd31;
			4'd12: r = 6'd33;
			4'd13: r = 6'd36;
			4'd14: r = 6'd39;
			default: r = 6'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== sv/cmn_cmd_if.sv =====
// Command channel: valid/ready handshake carrying one command word.
interface cmn_cmd_if import cmn_pkg::*; ();
	logic valid;
	logic ready;
	cmd_t word;

	modport source (output valid, output word, input ready);
	modport sink (input valid, input word, output ready);
endinterface

// ===== sv/cmn_rsp_if.sv =====
// Response channel: valid/ready handshake carrying one response word.
interface cmn_rsp_if import cmn_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t word;

	modport source (output valid, output word, input ready);
	modport sink (input valid, input word, output ready);
endinterface

// ===== sv/calendar_month_navigator.sv =====
// Calendar month navigator: holds a Gregorian date and answers one command per word.
// Takes one command word per clock cycle unless responses stall; each word gets one
// response word after the input register, two stages of jump-target preparation and
// the response register. The throughput of one word per cycle is set by the state
// update: year, month, day, year-mod-400 and first weekday are rewritten together, the
// weekday of the 1st being carried forward by month length on each step and taken from
// Zeller's congruence, computed ahead in the pipeline, on a jump. A stalled response
// holds its word while the pipeline keeps taking commands until its stages fill.
module calendar_month_navigator import cmn_pkg::*; (
	input logic clk,
	input logic arst_n,
	cmn_cmd_if.sink cmd,
	cmn_rsp_if.source rsp
);

	logic s3_valid;
	logic s3_ready;
	goto_t s3_word;

	cmn_prep u_prep (
		.clk (clk),
		.arst_n (arst_n),
		.cmd (cmd),
		.s3_valid (s3_valid),
		.s3_ready (s3_ready),
		.s3_word (s3_word)
	);

	cmn_state u_state (
		.clk (clk),
		.arst_n (arst_n),
		.s3_valid (s3_valid),
		.s3_ready (s3_ready),
		.s3_word (s3_word),
		.rsp (rsp)
	);

endmodule

// ===== sv/cmn_prep.sv =====
// Input register and two stages that clamp a jump target and find its first weekday.
module cmn_prep import cmn_pkg::*; (
	input logic clk,
	input logic arst_n,
	cmn_cmd_if.sink cmd,
	output logic s3_valid,
	input logic s3_ready,
	output goto_t s3_word
);

	logic en1, en2, en3;
	logic v_s1, v_s2, v_s3;
	cmd_t cmd_s1;

	func_t func_s2;
	logic [5:0] cell_s2;
	logic [13:0] year_s2;
	logic [3:0] month_s2;
	logic [4:0] tday_s2;
	logic leap_s2;
	logic [8:0] ymod_s2;
	logic [3:0] zm_s2;
	logic [6:0] zk_s2;
	logic [6:0] zj_s2;

	goto_t word_s3;

	logic [13:0] ty_c;
	logic [3:0] tm_c;
	logic [26:0] prod100;
	logic [6:0] j_t;
	logic [13:0] k_full;
	logic [6:0] k_t;
	logic leap_t;
	logic [8:0] ymod_t;
	logic [3:0] zm_t;
	logic [6:0] zk_t;
	logic [6:0] zj_t;

	logic [4:0] len2;
	logic [4:0] day_c;
	logic [9:0] zsum;
	logic [19:0] prod7;
	logic [6:0] q7;
	logic [2:0] h;
	logic [2:0] fd_t;

	assign en3 = !v_s3 || s3_ready;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign cmd.ready = en1;
	assign s3_valid = v_s3;
	assign s3_word = word_s3;

	always_comb begin
		ty_c = cmd_s1.target_year;
		if (ty_c < YEAR_MIN) begin
			ty_c = YEAR_MIN;
		end else if (ty_c > YEAR_MAX) begin
			ty_c = YEAR_MAX;
		end
		tm_c = cmd_s1.target_month;
		if (tm_c < MONTH_MIN) begin
			tm_c = MONTH_MIN;
		end else if (tm_c > MONTH_MAX) begin
			tm_c = MONTH_MAX;
		end
		prod100 = 27'(ty_c) * RECIP_100;
		j_t = 7'(prod100 >> RECIP_100_SHIFT);
		k_full = ty_c - 14'(j_t) * 14'(CENTURY);
		k_t = k_full[6:0];
		leap_t = ((k_t[1:0] == 2'd0) && (k_t != 7'd0)) ||
			((k_t == 7'd0) && (j_t[1:0] == 2'd0));
		ymod_t = 9'(j_t[1:0]) * CENTURY + 9'(k_t);
		// January and February count as months 13 and 14 of the year before
		zm_t = tm_c;
		zk_t = k_t;
		zj_t = j_t;
		if (tm_c < MONTH_MAR) begin
			zm_t = tm_c + MONTH_MAX;
			if (k_t == 7'd0) begin
				zk_t = 7'(CENTURY - 9'd1);
				zj_t = j_t - 7'd1;
			end else begin
				zk_t = k_t - 7'd1;
			end
		end
	end

	always_comb begin
		len2 = days_in(month_s2, leap_s2);
		day_c = tday_s2;
		if (day_c < DAY_MIN) begin
			day_c = DAY_MIN;
		end else if (day_c > len2) begin
			day_c = len2;
		end
		zsum = 10'd1 + 10'(zeller_m(zm_s2)) + 10'(zk_s2) + 10'(zk_s2 >> 2) +
			10'(zj_s2 >> 2) + 10'(zj_s2) * 10'd5;
		prod7 = 20'(zsum) * RECIP_7;
		q7 = 7'(prod7 >> RECIP_7_SHIFT);
		h = 3'(zsum - 10'(q7) * 10'(WEEK_DAYS));
		fd_t = (h == 3'd0) ? 3'(WEEK_DAYS) : h;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			word_s3 <= '0;
		end else begin
			if (en1) begin
				v_s1 <= cmd.valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
			if (en3 && v_s2) begin
				word_s3.func <= func_s2;
				word_s3.cell_idx <= cell_s2;
				word_s3.year <= year_s2;
				word_s3.month <= month_s2;
				word_s3.day <= day_c;
				word_s3.ymod <= ymod_s2;
				word_s3.fd <= fd_t;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && cmd.valid) begin
			cmd_s1 <= cmd.word;
		end
		if (en2 && v_s1) begin
			func_s2 <= cmd_s1.func;
			cell_s2 <= cmd_s1.cell_req;
			year_s2 <= ty_c;
			month_s2 <= tm_c;
			tday_s2 <= cmd_s1.target_day;
			leap_s2 <= leap_t;
			ymod_s2 <= ymod_t;
			zm_s2 <= zm_t;
			zk_s2 <= zk_t;
			zj_s2 <= zj_t;
		end
	end

endmodule

// ===== sv/cmn_state.sv =====
// Calendar state, month stepping, cell selection and the response register.
module cmn_state import cmn_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic s3_valid,
	output logic s3_ready,
	input goto_t s3_word,
	cmn_rsp_if.source rsp
);

	logic [13:0] year_q;
	logic [3:0] month_q;
	logic [4:0] day_q;
	logic [8:0] ymod_q;
	logic [2:0] fd_q;

	logic out_v_q;
	rsp_t rsp_q;
	logic take;

	logic [13:0] ny;
	logic [3:0] nm;
	logic [4:0] nday;
	logic [8:0] nymod;
	logic [2:0] nfd;
	logic ok;
	logic moved;
	logic [4:0] cur_len;
	logic [4:0] new_len;
	logic [2:0] shift;
	logic [3:0] fd_sum;
	logic [6:0] pos;
	logic [8:0] ymod_inc;
	logic [8:0] ymod_dec;

	assign s3_ready = !out_v_q || rsp.ready;
	assign take = s3_valid && s3_ready;
	assign rsp.valid = out_v_q;
	assign rsp.word = rsp_q;

	always_comb begin
		ny = year_q;
		nm = month_q;
		nday = day_q;
		nymod = ymod_q;
		nfd = fd_q;
		ok = 1'b1;
		moved = 1'b0;
		cur_len = days_in(month_q, leap_of(ymod_q));
		ymod_inc = (ymod_q == CYCLE_YEARS - 9'd1) ? 9'd0 : ymod_q + 9'd1;
		ymod_dec = (ymod_q == 9'd0) ? CYCLE_YEARS - 9'd1 : ymod_q - 9'd1;
		pos = 7'(s3_word.cell_idx) + CELL_OFS;
		unique case (s3_word.func)
			FUNC_PREV: begin
				if (month_q <= MONTH_MIN) begin
					if (year_q > YEAR_MIN) begin
						nm = MONTH_MAX;
						ny = year_q - 14'd1;
						nymod = ymod_dec;
						moved = 1'b1;
					end
				end else begin
					nm = month_q - 4'd1;
					moved = 1'b1;
				end
			end
			FUNC_NEXT: begin
				if (month_q >= MONTH_MAX) begin
					if (year_q < YEAR_MAX) begin
						nm = MONTH_MIN;
						ny = year_q + 14'd1;
						nymod = ymod_inc;
						moved = 1'b1;
					end
				end else begin
					nm = month_q + 4'd1;
					moved = 1'b1;
				end
			end
			FUNC_GOTO: begin
				ny = s3_word.year;
				nm = s3_word.month;
				nday = s3_word.day;
				nymod = s3_word.ymod;
				nfd = s3_word.fd;
			end
			FUNC_CELL: begin
				ok = 1'b0;
				if (s3_word.cell_idx < 6'(GRID_CELLS)) begin
					if (pos > 7'(fd_q) && (pos - 7'(fd_q)) <= 7'(cur_len)) begin
						nday = 5'(pos - 7'(fd_q));
						ok = 1'b1;
					end
				end
			end
		endcase
		new_len = days_in(nm, leap_of(nymod));
		// move the first weekday forward or back by the length of the month passed over
		shift = 3'((s3_word.func == FUNC_NEXT) ? cur_len - MIN_MONTH_LEN :
			new_len - MIN_MONTH_LEN);
		fd_sum = 4'(fd_q) + 4'(shift);
		if (moved) begin
			if (s3_word.func == FUNC_NEXT) begin
				nfd = (fd_sum > WEEK_DAYS) ? 3'(fd_sum - WEEK_DAYS) : 3'(fd_sum);
			end else begin
				nfd = (fd_q > shift) ? fd_q - shift :
					3'(4'(fd_q) + WEEK_DAYS - 4'(shift));
			end
		end
		if ((s3_word.func == FUNC_PREV || s3_word.func == FUNC_NEXT) && day_q > new_len) begin
			nday = new_len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			year_q <= RESET_YEAR;
			month_q <= RESET_MONTH;
			day_q <= RESET_DAY;
			ymod_q <= RESET_YMOD;
			fd_q <= RESET_FD;
			out_v_q <= 1'b0;
		end else begin
			if (take) begin
				year_q <= ny;
				month_q <= nm;
				day_q <= nday;
				ymod_q <= nymod;
				fd_q <= nfd;
			end
			if (s3_ready) begin
				out_v_q <= s3_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rsp_q.shown_year <= ny;
			rsp_q.shown_month <= nm;
			rsp_q.chosen_day <= nday;
			rsp_q.month_length <= new_len;
			rsp_q.first_weekday <= nfd;
			rsp_q.accepted <= ok;
		end
	end

`ifndef SYNTHESIS
	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		month_q >= MONTH_MIN && month_q <= MONTH_MAX &&
		year_q >= YEAR_MIN && year_q <= YEAR_MAX)
		else $error("date register out of range");

	a_fd_range: assert property (@(posedge clk) disable iff (!arst_n)
		fd_q >= 3'd1 && fd_q <= 3'(WEEK_DAYS))
		else $error("first weekday out of range");

	a_day_fits: assert property (@(posedge clk) disable iff (!arst_n)
		day_q >= DAY_MIN && day_q <= days_in(month_q, leap_of(ymod_q)))
		else $error("selected day outside month");

	a_reject_holds: assert property (@(posedge clk) disable iff (!arst_n)
		take && s3_word.func == FUNC_CELL && !ok |=>
		$stable(year_q) && $stable(month_q) && $stable(day_q) && $stable(fd_q))
		else $error("rejected cell changed state");

	a_next_step: assert property (@(posedge clk) disable iff (!arst_n)
		take && s3_word.func == FUNC_NEXT && month_q < MONTH_MAX |=>
		month_q == $past(month_q) + 4'd1 && year_q == $past(year_q))
		else $error("next month did not advance");
`endif

endmodule
